// File: rtl/pbn_pkg.sv
// shared constants, types and the blend weight table for the palette blend core
package pbn_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int FRAC_BITS    = 12;

    localparam int IDX_W     = $clog2(PALETTE_SIZE);
    localparam int IN_IDX_W  = 8;
    localparam int COMP_W    = 8;
    localparam int RGB_W     = 3 * COMP_W;
    localparam int SS_W      = 18;
    localparam int PCT_W     = 7;
    localparam int PCT_CODES = 1 << PCT_W;
    localparam int PCT_MAX   = 99;
    localparam int PCT_SCALE = 100;
    localparam int W_ONE     = 1 << FRAC_BITS;
    localparam int W_W       = FRAC_BITS + 1;
    localparam int BLEND_W   = COMP_W + FRAC_BITS;
    localparam int PROD_W    = COMP_W + BLEND_W;
    localparam int TOT_W     = SS_W + FRAC_BITS - 1;
    localparam int ERR_W     = SS_W + FRAC_BITS + 1;

    localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(66);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [2:0][COMP_W-1:0]  t_comp3;
    typedef logic [2:0][BLEND_W-1:0] t_opnd3;
    typedef logic [2:0][PROD_W-1:0]  t_prod3;
    typedef logic [PCT_CODES-1:0][W_W-1:0] t_w_tab;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_Q_C1,
        ST_Q_C2,
        ST_Q_BLEND,
        ST_Q_SCAN,
        ST_Q_OUT
    } t_state;

    // weight of the second color for every percent code, saturated at the top
    function automatic t_w_tab build_w_tab();
        t_w_tab tab;
        int     pct;
        for (int i = 0; i < PCT_CODES; i++) begin
            pct    = (i > PCT_MAX) ? PCT_MAX : i;
            tab[i] = W_W'((pct * W_ONE) / PCT_SCALE);
        end
        return tab;
    endfunction

    localparam t_w_tab W1_TAB = build_w_tab();

endpackage

// File: rtl/palette_blend_nearest_color_core.sv
// Palette blend nearest color core. A load (func 0) writes one palette entry and
// its squared magnitude; it passes through ST_LD_MUL and ST_LD_WR before it is idle again.
// A query (func 1) blends two entries with the percent register and scans the whole
// palette from the top index down, one entry per cycle through the single read port
// of the palette memory, so a query holds the input stalled after its accept, and
// its result is offered as the stall drops; a stalled earlier result stretches this.
// The result sits in an output register, so a load may be taken while it waits.
// Ties go to the higher index. Write the percent register only while the block is
// idle.
module palette_blend_nearest_color_core import pbn_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PCT_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [IN_IDX_W-1:0] i_first_index,
    input  logic [IN_IDX_W-1:0] i_second_index,
    input  logic [COMP_W-1:0]   i_red,
    input  logic [COMP_W-1:0]   i_green,
    input  logic [COMP_W-1:0]   i_blue,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [IN_IDX_W-1:0] o_best_index
);

    t_state                   r_state, n_state;
    logic [PCT_W-1:0]         r_pct;
    logic [IN_IDX_W-1:0]      r_first, r_second;
    t_comp3                   r_ld_rgb;

    logic [RGB_W+SS_W-1:0]    r_mem [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0]  r_valid;
    logic [RGB_W-1:0]         r_rd_rgb;
    logic [SS_W-1:0]          r_rd_ss;
    logic                     r_rd_ok;

    logic [IN_IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]         rd_addr;
    logic                     rd_inrange;
    logic                     ld_inrange;
    t_comp3                   rd_comp;
    logic [SS_W-1:0]          rd_ss;
    logic [SS_W-1:0]          ss_new;

    t_comp3                   mac_a;
    t_opnd3                   mac_b;
    t_prod3                   mac_p;
    t_opnd3                   r_acc, r_blend;
    logic [W_W-1:0]           w1, w2;

    logic [IDX_W-1:0]         r_scan_addr, r_i1, r_i2, r_i3, r_best_idx;
    logic                     r_issuing, r_v1, r_v2, r_v3, r_have;
    logic [TOT_W-1:0]         r_tot;
    logic signed [ERR_W-1:0]  r_err, r_best_err, err_calc;

    logic                     r_out_valid;
    logic [IN_IDX_W-1:0]      r_out_idx;

    logic                     accept, issue_en, take, scan_done, out_free;

    assign accept    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign issue_en  = (r_state == ST_Q_BLEND) || ((r_state == ST_Q_SCAN) && r_issuing);
    assign take      = r_v3 && (!r_have || (r_err < r_best_err));
    assign scan_done = r_v3 && (r_i3 == '0);

    assign w1 = W1_TAB[r_pct];
    assign w2 = W_W'(W_ONE) - w1;

    // read address per phase: first color, second color, then the scan
    always_comb begin
        unique case (r_state)
            ST_IDLE: rd_idx = i_first_index;
            ST_Q_C1: rd_idx = r_second;
            default: rd_idx = IN_IDX_W'(r_scan_addr);
        endcase
    end

    assign rd_addr    = rd_idx[IDX_W-1:0];
    assign rd_inrange = {1'b0, rd_idx} < (IN_IDX_W + 1)'(PALETTE_SIZE);
    assign ld_inrange = {1'b0, r_first} < (IN_IDX_W + 1)'(PALETTE_SIZE);
    assign rd_comp    = r_rd_ok ? r_rd_rgb : '0;
    assign rd_ss      = r_rd_ok ? r_rd_ss : '0;
    assign ss_new     = SS_W'(mac_p[0]) + SS_W'(mac_p[1]) + SS_W'(mac_p[2]);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LD_WR && ld_inrange) begin
            r_mem[r_first[IDX_W-1:0]] <= {r_ld_rgb, ss_new};
        end
        r_rd_rgb <= r_mem[rd_addr][RGB_W+SS_W-1:SS_W];
        r_rd_ss  <= r_mem[rd_addr][SS_W-1:0];
        r_rd_ok  <= r_valid[rd_addr] && rd_inrange;
    end

    // operand select for the shared multiplier
    always_comb begin
        mac_a = (r_state == ST_LD_MUL) ? r_ld_rgb : rd_comp;
        for (int k = 0; k < 3; k++) begin
            unique case (r_state)
                ST_LD_MUL: mac_b[k] = BLEND_W'(r_ld_rgb[k]);
                ST_Q_C1:   mac_b[k] = BLEND_W'(w2);
                ST_Q_C2:   mac_b[k] = BLEND_W'(w1);
                default:   mac_b[k] = r_blend[k];
            endcase
        end
    end

    pbn_mac u_mac (
        .i_clk  (i_clk),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (mac_p)
    );

    assign err_calc = $signed(ERR_W'(r_tot)) - $signed(ERR_W'(mac_p[0]))
                    - $signed(ERR_W'(mac_p[1])) - $signed(ERR_W'(mac_p[2]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_func == FUNC_LOAD) ? ST_LD_MUL : ST_Q_C1;
                end
            end
            ST_LD_MUL:  n_state = ST_LD_WR;
            ST_LD_WR:   n_state = ST_IDLE;
            ST_Q_C1:    n_state = ST_Q_C2;
            ST_Q_C2:    n_state = ST_Q_BLEND;
            ST_Q_BLEND: n_state = ST_Q_SCAN;
            ST_Q_SCAN: begin
                if (scan_done) begin
                    n_state = ST_Q_OUT;
                end
            end
            ST_Q_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pct       <= PCT_RESET;
            r_valid     <= '0;
            r_issuing   <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_pct <= i_cfg_wdata;
            end
            if (r_state == ST_LD_WR && ld_inrange) begin
                r_valid[r_first[IDX_W-1:0]] <= 1'b1;
            end
            if (accept) begin
                r_issuing <= 1'b1;
                r_have    <= 1'b0;
            end else begin
                if (issue_en && r_scan_addr == '0) begin
                    r_issuing <= 1'b0;
                end
                if (take) begin
                    r_have <= 1'b1;
                end
            end
            r_v1 <= issue_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_state == ST_Q_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first     <= i_first_index;
            r_second    <= i_second_index;
            r_ld_rgb    <= {i_red, i_green, i_blue};
            r_scan_addr <= IDX_W'(PALETTE_SIZE - 1);
        end else if (issue_en && r_scan_addr != '0) begin
            r_scan_addr <= r_scan_addr - IDX_W'(1);
        end
        if (r_state == ST_Q_C2) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= BLEND_W'(mac_p[k]);
            end
        end
        if (r_state == ST_Q_BLEND) begin
            for (int k = 0; k < 3; k++) begin
                r_blend[k] <= r_acc[k] + BLEND_W'(mac_p[k]);
            end
        end
        r_i1  <= r_scan_addr;
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_tot <= TOT_W'(rd_ss) << (FRAC_BITS - 1);
        r_err <= err_calc;
        if (take) begin
            r_best_err <= r_err;
            r_best_idx <= r_i3;
        end
        if (r_state == ST_Q_OUT && out_free) begin
            r_out_idx <= IN_IDX_W'(r_best_idx);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_index = r_out_idx;

endmodule

// File: rtl/pbn_mac.sv
// shared triple multiplier with registered products
module pbn_mac import pbn_pkg::*; (
    input  logic   i_clk,
    input  t_comp3 i_a,
    input  t_opnd3 i_b,
    output t_prod3 o_prod
);

    t_prod3 r_prod;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= PROD_W'(i_a[k]) * PROD_W'(i_b[k]);
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/pbn_checker.sv
// port-level checks for the palette blend core, bound to the top level
module pbn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_best_index
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_best_index))
        else $error("result index changed while stalled");

    // every transaction keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // a new result only comes out of a running query
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a query in flight");

endmodule

bind palette_blend_nearest_color_core pbn_checker u_pbn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_best_index (o_best_index)
);

// File: tb/palette_blend_nearest_color_core_tb.sv
// testbench for the palette blend nearest color core: palette loads, blend queries, checking
`timescale 1ns / 100ps

module palette_blend_nearest_color_core_tb;
    import pbn_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 1500;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RAND_PER_PHASE = 90;
    localparam int NUM_PHASES     = 5;
    localparam int LIMIT_CYCLES   = 1_000_000;

    // palette image, blend predictor and queue of expected best indexes
    class blend_scoreboard;
        t_comp3              palette [PALETTE_SIZE];
        int unsigned         sq_sum [PALETTE_SIZE];
        logic [PCT_W-1:0]    pct;
        logic [IN_IDX_W-1:0] best_q [$];
        int                  errors;
        int                  n_loads;
        int                  n_queries;
        int                  n_results;

        function new();
            foreach (palette[i]) begin
                palette[i] = '0;
                sq_sum[i]  = 0;
            end
            pct       = PCT_RESET;
            errors    = 0;
            n_loads   = 0;
            n_queries = 0;
            n_results = 0;
        endfunction

        function void set_pct(logic [PCT_W-1:0] value);
            pct = value;
        endfunction

        function int pending();
            return best_q.size();
        endfunction

        // indexes past the palette read as black
        function t_comp3 entry_at(logic [IN_IDX_W-1:0] idx);
            if (idx < PALETTE_SIZE)
                return palette[idx];
            return '0;
        endfunction

        function logic [IN_IDX_W-1:0] nearest_to_blend(logic [IN_IDX_W-1:0] a,
                                                       logic [IN_IDX_W-1:0] b);
            t_comp3              c1;
            t_comp3              c2;
            longint              w1;
            longint              w2;
            longint              err;
            longint              best;
            longint              mix [3];
            int                  eff;
            logic [IN_IDX_W-1:0] best_idx;
            eff  = (pct > PCT_MAX) ? PCT_MAX : int'(pct);
            w1   = (longint'(eff) * W_ONE) / PCT_SCALE;
            w2   = W_ONE - w1;
            c1   = entry_at(a);
            c2   = entry_at(b);
            best = 0;
            best_idx = '0;
            for (int k = 0; k < 3; k++)
                mix[k] = longint'(c2[k]) * w1 + longint'(c1[k]) * w2;
            // scan from the top, strict compare keeps the higher index on a tie
            for (int i = PALETTE_SIZE - 1; i >= 0; i--) begin
                err = longint'(sq_sum[i]) << (FRAC_BITS - 1);
                for (int k = 0; k < 3; k++)
                    err -= longint'(palette[i][k]) * mix[k];
                if (i == PALETTE_SIZE - 1 || err < best) begin
                    best     = err;
                    best_idx = IN_IDX_W'(i);
                end
            end
            return best_idx;
        endfunction

        function void note_input(logic func, logic [IN_IDX_W-1:0] a,
                                 logic [IN_IDX_W-1:0] b, logic [COMP_W-1:0] r,
                                 logic [COMP_W-1:0] g, logic [COMP_W-1:0] bl);
            if (func == FUNC_LOAD) begin
                n_loads++;
                if (a < PALETTE_SIZE) begin
                    palette[a] = {r, g, bl};
                    sq_sum[a]  = int'(r) * int'(r) + int'(g) * int'(g) + int'(bl) * int'(bl);
                end
            end else begin
                n_queries++;
                best_q.push_back(nearest_to_blend(a, b));
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [IN_IDX_W-1:0] got);
            logic [IN_IDX_W-1:0] want;
            n_results++;
            if (best_q.size() == 0) begin
                report($sformatf("best_index %0d arrived with no query waiting", got));
            end else begin
                want = best_q.pop_front();
                if (got !== want)
                    report($sformatf("best_index got %0d, want %0d", got, want));
            end
        endtask

        task close_out();
            if (best_q.size() != 0)
                report($sformatf("%0d queries never answered", best_q.size()));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PCT_W-1:0]    i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_func;
    logic [IN_IDX_W-1:0] i_first_index;
    logic [IN_IDX_W-1:0] i_second_index;
    logic [COMP_W-1:0]   i_red;
    logic [COMP_W-1:0]   i_green;
    logic [COMP_W-1:0]   i_blue;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [IN_IDX_W-1:0] o_best_index;

    blend_scoreboard     sb = new();
    bit                  pressure_on = 1'b0;
    bit                  gaps_on = 1'b1;
    logic [IN_IDX_W-1:0] recent [8];
    int                  recent_ptr = 0;
    int                  n_settings = 1;
    int                  cycles = 0;

    palette_blend_nearest_color_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_best_index   (o_best_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // both handshakes sampled at the edge, before any drive of this edge lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_func, i_first_index, i_second_index, i_red, i_green, i_blue);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_best_index);
        end
    end

    // result side: calm stretches, choppy stretches, long stalls, one long hold-off
    initial begin
        int  seg;
        int  n;
        bit  pressure_done;
        pressure_done = 1'b0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (pressure_on && !pressure_done) begin
                pressure_done = 1'b1;
                i_out_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge i_clk);
            end else begin
                seg = $urandom_range(0, 9);
                if (seg < 3) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(20, 200)) @(posedge i_clk);
                end else if (seg < 9) begin
                    repeat ($urandom_range(5, 40)) begin
                        i_out_stall <= ($urandom_range(0, 2) == 0);
                        @(posedge i_clk);
                    end
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(20, 80)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic logic [COMP_W-1:0] pick_comp();
        logic [COMP_W-1:0] corner_vals [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(0, 9) < 3)
            return corner_vals[$urandom_range(0, 5)];
        return COMP_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [IN_IDX_W-1:0] pick_query_index();
        if ($urandom_range(0, 9) < 4)
            return recent[$urandom_range(0, 7)];
        return IN_IDX_W'($urandom_range(0, 255));
    endfunction

    task automatic idle_input(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // offer one transaction and return at the edge that takes it
    task automatic send_item(input logic func, input logic [IN_IDX_W-1:0] a,
                             input logic [IN_IDX_W-1:0] b, input logic [COMP_W-1:0] r,
                             input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] bl);
        idle_input(sender_gap());
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_first_index  <= a;
        i_second_index <= b;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= bl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // unused fields carry random values on every transaction
    task automatic load_entry(input logic [IN_IDX_W-1:0] idx, input logic [COMP_W-1:0] r,
                              input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] bl);
        send_item(FUNC_LOAD, idx, IN_IDX_W'($urandom), r, g, bl);
        recent[recent_ptr] = idx;
        recent_ptr = (recent_ptr + 1) % 8;
    endtask

    task automatic query_blend(input logic [IN_IDX_W-1:0] a, input logic [IN_IDX_W-1:0] b);
        send_item(FUNC_QUERY, a, b, COMP_W'($urandom), COMP_W'($urandom), COMP_W'($urandom));
    endtask

    task automatic random_item();
        logic [IN_IDX_W-1:0] idx;
        t_comp3              c;
        if ($urandom_range(0, 99) < 55) begin
            if ($urandom_range(0, 3) == 0)
                idx = $urandom_range(0, 1) ? IN_IDX_W'($urandom_range(0, 7))
                                           : IN_IDX_W'($urandom_range(248, 255));
            else
                idx = IN_IDX_W'($urandom_range(0, 255));
            // copying an existing color sets up ties between entries
            if ($urandom_range(0, 3) == 0)
                c = sb.palette[$urandom_range(0, PALETTE_SIZE - 1)];
            else
                c = {pick_comp(), pick_comp(), pick_comp()};
            load_entry(idx, c[2], c[1], c[0]);
        end else begin
            query_blend(pick_query_index(), pick_query_index());
        end
    endtask

    task automatic settle();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_percent(input logic [PCT_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        sb.set_pct(value);
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    initial begin
        logic [PCT_W-1:0] phase_pct [NUM_PHASES];
        phase_pct = '{7'd0, 7'd99, 7'd127, 7'd100, PCT_W'($urandom_range(1, 98))};
        foreach (recent[i])
            recent[i] = '0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_func         <= FUNC_LOAD;
        i_first_index  <= '0;
        i_second_index <= '0;
        i_red          <= '0;
        i_green        <= '0;
        i_blue         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cleared palette: every entry ties, the top index wins
        query_blend(8'd0, 8'd255);
        load_entry(8'd0, 8'd255, 8'd255, 8'd255);
        load_entry(8'd255, 8'd0, 8'd0, 8'd0);
        load_entry(8'd1, 8'd255, 8'd0, 8'd0);
        load_entry(8'd2, 8'd0, 8'd255, 8'd0);
        load_entry(8'd3, 8'd0, 8'd0, 8'd255);
        load_entry(8'd128, 8'd255, 8'd255, 8'd255);
        load_entry(8'd254, 8'd128, 8'd127, 8'd1);
        query_blend(8'd0, 8'd0);
        query_blend(8'd255, 8'd255);
        query_blend(8'd1, 8'd2);
        query_blend(8'd2, 8'd3);
        query_blend(8'd3, 8'd1);
        query_blend(8'd0, 8'd255);
        query_blend(8'd255, 8'd0);
        query_blend(8'd128, 8'd254);
        query_blend(8'd254, 8'd254);
        // overwrite the top entry, white now ties three ways
        load_entry(8'd255, 8'd255, 8'd255, 8'd255);
        query_blend(8'd0, 8'd0);
        query_blend(8'd1, 8'd1);
        idle_input(1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_percent(phase_pct[p]);
            if (p == 1)
                pressure_on <= 1'b1;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                gaps_on = (n >= 30);
                random_item();
            end
            idle_input(1);
        end

        settle();
        sb.close_out();
        $display("covered %0d loads and %0d queries under %0d percent settings",
                 sb.n_loads, sb.n_queries, n_settings);
        $display("%0d results checked, %0d mismatches", sb.n_results, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
